### rtl/bksq_pkg.sv
// Package: types, constants and GF(2^8) functions for the BKSQ encryptor
package bksq_pkg;

  localparam int RoundCountDefault = 10;
  localparam int BlockBytes = 12;

  typedef logic [7:0] byte_t;
  typedef byte_t [BlockBytes-1:0] block_t;

  typedef struct packed {
    logic [47:0] plain_hi;
    logic [47:0] plain_lo;
    logic [47:0] key_hi;
    logic [47:0] key_lo;
  } in_item_t;

  typedef struct packed {
    logic [47:0] cipher_hi;
    logic [47:0] cipher_lo;
  } out_item_t;

  localparam logic [3:0] BytePerm [BlockBytes] = '{
    4'd0, 4'd10, 4'd8, 4'd3, 4'd1, 4'd11, 4'd6, 4'd4, 4'd2, 4'd9, 4'd7, 4'd5
  };

  localparam byte_t SboxTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t xtime(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t acc;
    byte_t x;
    acc = '0;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = xtime(x);
    end
    return acc;
  endfunction

  // circulant (d,o,o) on each group of three bytes; index 0 is byte 0
  function automatic block_t circ_mix(block_t s, byte_t d, byte_t o);
    block_t r;
    for (int g = 0; g < BlockBytes; g += 3) begin
      r[g]   = gf_mul(s[g], d) ^ gf_mul(s[g+1], o) ^ gf_mul(s[g+2], o);
      r[g+1] = gf_mul(s[g], o) ^ gf_mul(s[g+1], d) ^ gf_mul(s[g+2], o);
      r[g+2] = gf_mul(s[g], o) ^ gf_mul(s[g+1], o) ^ gf_mul(s[g+2], d);
    end
    return r;
  endfunction

  function automatic block_t unpack(logic [47:0] hi, logic [47:0] lo);
    block_t b;
    for (int i = 0; i < 6; i++) begin
      b[i]   = hi[47-8*i -: 8];
      b[i+6] = lo[47-8*i -: 8];
    end
    return b;
  endfunction

endpackage

### rtl/bksq_block_encrypt_unit.sv
// Top level: pipelined BKSQ block encryptor, one round cell per round
//
//   channel | signals                 | payload
//   in      | in_valid, in_ready      | bksq_pkg::in_item_t
//   out     | out_valid, out_ready    | bksq_pkg::out_item_t
//
// One transaction per cycle sustained while the output is not stalled.
// An input stage does inverse theta and whitening, then one cell per round.
// The whole pipe advances together whenever the output register is empty
// or being taken; a stalled output freezes every stage.
// Reset clears all valid bits; payload registers are not reset.
module bksq_block_encrypt_unit #(
  parameter int ROUND_COUNT = bksq_pkg::RoundCountDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bksq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bksq_pkg::out_item_t  out_data
);

  logic             en;
  logic             v   [ROUND_COUNT+1];
  bksq_pkg::block_t st  [ROUND_COUNT+1];
  bksq_pkg::block_t key [ROUND_COUNT+1];

  assign en       = !v[ROUND_COUNT] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      key[0] <= bksq_pkg::unpack(in_data.key_hi, in_data.key_lo);
      st[0]  <= bksq_pkg::circ_mix(bksq_pkg::unpack(in_data.plain_hi, in_data.plain_lo),
                                   8'd246, 8'd247)
                ^ bksq_pkg::unpack(in_data.key_hi, in_data.key_lo);
    end
  end

  function automatic bksq_pkg::byte_t rcon(int r);
    bksq_pkg::byte_t c;
    c = 8'h01;
    for (int i = 0; i < r; i++) c = bksq_pkg::xtime(c);
    return c;
  endfunction

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    bksq_round_cell #(.RCON(rcon(r + 1))) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (v[r]),
      .st_in    (st[r]),
      .key_in   (key[r]),
      .valid_out(v[r+1]),
      .st_out   (st[r+1]),
      .key_out  (key[r+1])
    );
  end

  assign out_valid = v[ROUND_COUNT];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      out_data.cipher_hi[47-8*i -: 8] = st[ROUND_COUNT][i];
      out_data.cipher_lo[47-8*i -: 8] = st[ROUND_COUNT][i+6];
    end
  end

endmodule

### rtl/bksq_round_cell.sv
// Cell: one BKSQ round with its key update, registered
module bksq_round_cell #(
  parameter bksq_pkg::byte_t RCON = 8'h02
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_in,
  input  bksq_pkg::block_t st_in,
  input  bksq_pkg::block_t key_in,
  output logic             valid_out,
  output bksq_pkg::block_t st_out,
  output bksq_pkg::block_t key_out
);

  bksq_pkg::block_t mix;
  bksq_pkg::block_t st_next;
  bksq_pkg::block_t key_next;

  always_comb begin
    key_next[0] = key_in[0] ^ bksq_pkg::SboxTab[key_in[10]] ^ RCON;
    key_next[1] = key_in[1] ^ bksq_pkg::SboxTab[key_in[11]];
    key_next[2] = key_in[2] ^ bksq_pkg::SboxTab[key_in[9]];
    for (int i = 3; i < bksq_pkg::BlockBytes; i++) begin
      key_next[i] = key_in[i] ^ key_next[i-3];
    end
    mix = bksq_pkg::circ_mix(st_in, 8'd3, 8'd2);
    for (int i = 0; i < bksq_pkg::BlockBytes; i++) begin
      st_next[i] = bksq_pkg::SboxTab[mix[bksq_pkg::BytePerm[i]]] ^ key_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
    if (en) begin
      st_out  <= st_next;
      key_out <= key_next;
    end
  end

endmodule

### rtl/bksq_block_encrypt_unit_checker.sv
// Checker: port-level assertions for the BKSQ encryptor, bound to the top level
module bksq_block_encrypt_unit_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bksq_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction dropped before acceptance");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind bksq_block_encrypt_unit bksq_block_encrypt_unit_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
